FILE: hw/rtl/erv_pkg.sv
// constants shared by the euler rotation pipeline: angle reduction,
// degree to radian scale and the taylor series divisor reciprocals
// no dependencies
package erv_pkg;

    localparam int ANGLE_WIDTH = 32;

    // angle reduction: offset is a multiple of 360 deg that makes any angle positive
    localparam logic [32:0] ANGLE_OFFSET    = 33'd2170552320;
    localparam int          DEG_SHIFT       = 19;
    localparam logic [14:0] DEG_RECIP       = 15'd23302;
    localparam int          DEG_RECIP_SHIFT = 20;
    localparam logic [24:0] DEG_FULL        = 25'd23592960;
    localparam logic [24:0] DEG_QUART       = 25'd5898240;
    localparam logic [24:0] DEG_HALF        = 25'd11796480;
    localparam logic [24:0] DEG_3QUART      = 25'd17694720;

    // round(pi/180 * 2^40)
    localparam logic [34:0] RAD_K = 35'd19190098069;

    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    localparam int TERMS = 7;

    // exact quotient of a 33 bit numerator: (n * MUL) >> SHIFT
    localparam logic [33:0] SIN_MUL [TERMS] = '{
        34'(((64'd1 << 36) + 64'd5) / 64'd6),
        34'(((64'd1 << 38) + 64'd19) / 64'd20),
        34'(((64'd1 << 39) + 64'd41) / 64'd42),
        34'(((64'd1 << 40) + 64'd71) / 64'd72),
        34'(((64'd1 << 40) + 64'd109) / 64'd110),
        34'(((64'd1 << 41) + 64'd155) / 64'd156),
        34'(((64'd1 << 41) + 64'd209) / 64'd210)
    };
    localparam int SIN_SHIFT [TERMS] = '{36, 38, 39, 40, 40, 41, 41};

    localparam logic [33:0] COS_MUL [TERMS] = '{
        34'(((64'd1 << 34) + 64'd1) / 64'd2),
        34'(((64'd1 << 37) + 64'd11) / 64'd12),
        34'(((64'd1 << 38) + 64'd29) / 64'd30),
        34'(((64'd1 << 39) + 64'd55) / 64'd56),
        34'(((64'd1 << 40) + 64'd89) / 64'd90),
        34'(((64'd1 << 41) + 64'd131) / 64'd132),
        34'(((64'd1 << 41) + 64'd181) / 64'd182)
    };
    localparam int COS_SHIFT [TERMS] = '{34, 37, 38, 39, 40, 41, 41};

    // pipeline depths
    localparam int TRIG_LAT = 2 * TERMS + 7;
    localparam int ROT_LAT  = 2;

endpackage

FILE: hw/rtl/erv_if.sv
// valid/ready channels for points in and rotated points out
// depends on erv_pkg for the angle width
interface erv_in_if
    import erv_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] vec_x;
    logic signed [COORD_WIDTH-1:0] vec_y;
    logic signed [COORD_WIDTH-1:0] vec_z;
    logic signed [ANGLE_WIDTH-1:0] roll_deg;
    logic signed [ANGLE_WIDTH-1:0] pitch_deg;
    logic signed [ANGLE_WIDTH-1:0] yaw_deg;

    modport source (output valid, vec_x, vec_y, vec_z, roll_deg, pitch_deg, yaw_deg,
                    input ready);
    modport sink (input valid, vec_x, vec_y, vec_z, roll_deg, pitch_deg, yaw_deg,
                  output ready);
endinterface

interface erv_out_if #(
    parameter int COORD_WIDTH = 32
) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rot_x;
    logic signed [COORD_WIDTH-1:0] rot_y;
    logic signed [COORD_WIDTH-1:0] rot_z;
    logic                          overflow;

    modport source (output valid, rot_x, rot_y, rot_z, overflow, input ready);
    modport sink (input valid, rot_x, rot_y, rot_z, overflow, output ready);
endinterface

FILE: hw/rtl/erv_trig.sv
// sine and cosine of one angle in degrees, pipelined taylor series
// depends on erv_pkg
module erv_trig
    import erv_pkg::*;
#(
    parameter int TRIG_FRAC_BITS = 16,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [ANGLE_WIDTH-1:0] angle,
    output logic signed [TW-1:0]          sin_val,
    output logic signed [TW-1:0]          cos_val
);

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    // reduction to [0, 360) and quadrant split
    logic [32:0] u_next;
    logic [28:0] qp_next;
    logic [32:0] u_reg;
    logic [28:0] qp_reg;
    logic [24:0] m_next;
    logic [24:0] m_reg;
    quad_t       quad_next;
    logic [22:0] r_next;
    quad_t       quad3_reg;
    logic [22:0] r_reg;
    logic [57:0] rp_reg;
    quad_t       quad4_reg;
    logic [30:0] th;
    logic [30:0] th_reg;
    logic [61:0] sq_reg;
    quad_t       quad5_reg;

    assign u_next  = {angle[ANGLE_WIDTH-1], angle} + ANGLE_OFFSET;
    assign qp_next = 29'(u_next[32:DEG_SHIFT]) * 29'(DEG_RECIP);
    assign m_next  = 25'(u_reg - 33'(qp_reg[27:DEG_RECIP_SHIFT]) * 33'(DEG_FULL));
    assign th      = rp_reg[56:26];

    always_comb
    begin
        if (m_reg >= DEG_3QUART)
        begin
            quad_next = QUAD_3;
            r_next    = 23'(m_reg - DEG_3QUART);
        end
        else if (m_reg >= DEG_HALF)
        begin
            quad_next = QUAD_2;
            r_next    = 23'(m_reg - DEG_HALF);
        end
        else if (m_reg >= DEG_QUART)
        begin
            quad_next = QUAD_1;
            r_next    = 23'(m_reg - DEG_QUART);
        end
        else
        begin
            quad_next = QUAD_0;
            r_next    = m_reg[22:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg     <= u_next;
            qp_reg    <= qp_next;
            m_reg     <= m_next;
            quad3_reg <= quad_next;
            r_reg     <= r_next;
            rp_reg    <= 58'(r_reg) * 58'(RAD_K);
            quad4_reg <= quad3_reg;
            th_reg    <= th;
            sq_reg    <= 62'(th) * 62'(th);
            quad5_reg <= quad4_reg;
        end
    end

    // series terms: stage a multiplies by x^2, stage b divides by the term constant
    logic [30:0]        ts_in    [TERMS];
    logic [30:0]        tc_in    [TERMS];
    logic signed [33:0] accs_in  [TERMS];
    logic signed [33:0] accc_in  [TERMS];
    logic [31:0]        x2_in    [TERMS];
    quad_t              quad_in  [TERMS];

    logic [62:0]        pa_s_reg [TERMS];
    logic [62:0]        pa_c_reg [TERMS];
    logic signed [33:0] acca_s_reg [TERMS];
    logic signed [33:0] acca_c_reg [TERMS];
    logic [31:0]        x2a_reg  [TERMS];
    quad_t              quada_reg [TERMS];

    logic [66:0]        pb_s_reg [TERMS];
    logic [66:0]        pb_c_reg [TERMS];
    logic signed [33:0] accb_s_reg [TERMS];
    logic signed [33:0] accb_c_reg [TERMS];
    logic [31:0]        x2b_reg  [TERMS];
    quad_t              quadb_reg [TERMS];

    for (genvar k = 0; k < TERMS; k++)
    begin : g_term
        if (k == 0)
        begin : g_first
            assign ts_in[k]   = th_reg;
            assign tc_in[k]   = Q30_ONE;
            assign accs_in[k] = $signed({3'b000, th_reg});
            assign accc_in[k] = $signed({3'b000, Q30_ONE});
            assign x2_in[k]   = sq_reg[61:30];
            assign quad_in[k] = quad5_reg;
        end
        else
        begin : g_next
            assign ts_in[k] = 31'(pb_s_reg[k-1] >> SIN_SHIFT[k-1]);
            assign tc_in[k] = 31'(pb_c_reg[k-1] >> COS_SHIFT[k-1]);
            // odd numbered terms subtract
            if ((k - 1) % 2 == 0)
            begin : g_sub
                assign accs_in[k] = accb_s_reg[k-1] - $signed({3'b000, ts_in[k]});
                assign accc_in[k] = accb_c_reg[k-1] - $signed({3'b000, tc_in[k]});
            end
            else
            begin : g_add
                assign accs_in[k] = accb_s_reg[k-1] + $signed({3'b000, ts_in[k]});
                assign accc_in[k] = accb_c_reg[k-1] + $signed({3'b000, tc_in[k]});
            end
            assign x2_in[k]   = x2b_reg[k-1];
            assign quad_in[k] = quadb_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pa_s_reg[k]   <= 63'(ts_in[k]) * 63'(x2_in[k]);
                pa_c_reg[k]   <= 63'(tc_in[k]) * 63'(x2_in[k]);
                acca_s_reg[k] <= accs_in[k];
                acca_c_reg[k] <= accc_in[k];
                x2a_reg[k]    <= x2_in[k];
                quada_reg[k]  <= quad_in[k];

                pb_s_reg[k]   <= 67'(pa_s_reg[k][62:30]) * 67'(SIN_MUL[k]);
                pb_c_reg[k]   <= 67'(pa_c_reg[k][62:30]) * 67'(COS_MUL[k]);
                accb_s_reg[k] <= acca_s_reg[k];
                accb_c_reg[k] <= acca_c_reg[k];
                x2b_reg[k]    <= x2a_reg[k];
                quadb_reg[k]  <= quada_reg[k];
            end
        end
    end

    // last term, then clamp, round and quadrant map
    logic [30:0]               ts_last;
    logic [30:0]               tc_last;
    logic signed [33:0]        sum_s_reg;
    logic signed [33:0]        sum_c_reg;
    quad_t                     quadf_reg;
    logic [30:0]               clamp_s;
    logic [30:0]               clamp_c;
    logic [TRIG_FRAC_BITS:0]   mag_s;
    logic [TRIG_FRAC_BITS:0]   mag_c;
    logic signed [TW-1:0]      pos_s;
    logic signed [TW-1:0]      pos_c;
    logic signed [TW-1:0]      sin_next;
    logic signed [TW-1:0]      cos_next;

    assign ts_last = 31'(pb_s_reg[TERMS-1] >> SIN_SHIFT[TERMS-1]);
    assign tc_last = 31'(pb_c_reg[TERMS-1] >> COS_SHIFT[TERMS-1]);

    always_comb
    begin
        if (sum_s_reg < 0)
            clamp_s = '0;
        else if (sum_s_reg > $signed({3'b000, Q30_ONE}))
            clamp_s = Q30_ONE;
        else
            clamp_s = sum_s_reg[30:0];

        if (sum_c_reg < 0)
            clamp_c = '0;
        else if (sum_c_reg > $signed({3'b000, Q30_ONE}))
            clamp_c = Q30_ONE;
        else
            clamp_c = sum_c_reg[30:0];

        mag_s = (TRIG_FRAC_BITS + 1)'((32'(clamp_s) + (32'd1 << (29 - TRIG_FRAC_BITS)))
                                      >> (30 - TRIG_FRAC_BITS));
        mag_c = (TRIG_FRAC_BITS + 1)'((32'(clamp_c) + (32'd1 << (29 - TRIG_FRAC_BITS)))
                                      >> (30 - TRIG_FRAC_BITS));
        pos_s = $signed({1'b0, mag_s});
        pos_c = $signed({1'b0, mag_c});

        case (quadf_reg)
            QUAD_0:
            begin
                sin_next = pos_s;
                cos_next = pos_c;
            end
            QUAD_1:
            begin
                sin_next = pos_c;
                cos_next = -pos_s;
            end
            QUAD_2:
            begin
                sin_next = -pos_s;
                cos_next = -pos_c;
            end
            default:
            begin
                sin_next = -pos_c;
                cos_next = pos_s;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_s_reg <= accb_s_reg[TERMS-1] - $signed({3'b000, ts_last});
            sum_c_reg <= accb_c_reg[TERMS-1] - $signed({3'b000, tc_last});
            quadf_reg <= quadb_reg[TERMS-1];
            sin_val   <= sin_next;
            cos_val   <= cos_next;
        end
    end

endmodule

FILE: hw/rtl/erv_rot_step.sv
// one plane rotation: a*c - b*s and a*s + b*c, rounded half up and saturated
// two register stages; no package dependency
module erv_rot_step #(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC_BITS = 16,
    localparam int TW = TRIG_FRAC_BITS + 2
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [COORD_WIDTH-1:0] a,
    input  logic signed [COORD_WIDTH-1:0] b,
    input  logic signed [TW-1:0]          c,
    input  logic signed [TW-1:0]          s,
    input  logic                          ovf_in,
    output logic signed [COORD_WIDTH-1:0] diff_val,
    output logic signed [COORD_WIDTH-1:0] sum_val,
    output logic                          ovf_out
);

    localparam int PW = COORD_WIDTH + TW;
    localparam int SW = COORD_WIDTH + 3;
    localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [SW-1:0] MAX_EXT = $signed({4'b0000, {(COORD_WIDTH-1){1'b1}}});
    localparam logic signed [SW-1:0] MIN_EXT = -MAX_EXT - SW'(1);

    logic signed [PW-1:0] pac_reg;
    logic signed [PW-1:0] pbs_reg;
    logic signed [PW-1:0] pas_reg;
    logic signed [PW-1:0] pbc_reg;
    logic                 ovf1_reg;

    logic signed [PW:0]   diff_full;
    logic signed [PW:0]   sum_full;
    logic signed [SW-1:0] diff_sh;
    logic signed [SW-1:0] sum_sh;
    logic signed [COORD_WIDTH-1:0] diff_next;
    logic signed [COORD_WIDTH-1:0] sum_next;
    logic                 diff_ovf;
    logic                 sum_ovf;

    always_comb
    begin
        diff_full = (PW + 1)'(pac_reg) - (PW + 1)'(pbs_reg) + HALF;
        sum_full  = (PW + 1)'(pas_reg) + (PW + 1)'(pbc_reg) + HALF;
        diff_sh   = SW'(diff_full >>> TRIG_FRAC_BITS);
        sum_sh    = SW'(sum_full >>> TRIG_FRAC_BITS);

        diff_ovf  = 1'b1;
        if (diff_sh > MAX_EXT)
            diff_next = MAX_EXT[COORD_WIDTH-1:0];
        else if (diff_sh < MIN_EXT)
            diff_next = MIN_EXT[COORD_WIDTH-1:0];
        else
        begin
            diff_next = diff_sh[COORD_WIDTH-1:0];
            diff_ovf  = 1'b0;
        end

        sum_ovf = 1'b1;
        if (sum_sh > MAX_EXT)
            sum_next = MAX_EXT[COORD_WIDTH-1:0];
        else if (sum_sh < MIN_EXT)
            sum_next = MIN_EXT[COORD_WIDTH-1:0];
        else
        begin
            sum_next = sum_sh[COORD_WIDTH-1:0];
            sum_ovf  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pac_reg  <= PW'(a) * PW'(c);
            pbs_reg  <= PW'(b) * PW'(s);
            pas_reg  <= PW'(a) * PW'(s);
            pbc_reg  <= PW'(b) * PW'(c);
            ovf1_reg <= ovf_in;
            diff_val <= diff_next;
            sum_val  <= sum_next;
            ovf_out  <= ovf1_reg | diff_ovf | sum_ovf;
        end
    end

endmodule

FILE: hw/rtl/euler_rotate_vector3.sv
// euler_rotate_vector3: rotates a Q16.16 point about X (roll), Y (pitch), Z (yaw)
// uses erv_pkg, erv_if, erv_trig, erv_rot_step
//
// One request per clock while the skid register is empty; point.ready is low while it is full.
// A request passes through the sine/cosine pipeline (five reduction stages, two stages
// per series term for seven terms, two finishing stages), then three rotation
// steps of two stages each and the output register. A skid register behind the
// pipeline lets a new request in while a finished result waits to be taken.
module euler_rotate_vector3
    import erv_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int TRIG_FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    erv_in_if.sink     point,
    erv_out_if.source  result
);

    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int PIPE_LAT = TRIG_LAT + 3 * ROT_LAT;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic                          ovf;
    } res_t;

    logic                adv;
    logic [PIPE_LAT-1:0] valid_reg;
    logic                skid_full_reg;
    res_t                skid_reg;
    logic                out_valid_reg;
    res_t                out_reg;
    res_t                last;

    assign adv         = !skid_full_reg;
    assign point.ready = adv;

    // coordinates wait alongside the trig pipeline
    logic signed [COORD_WIDTH-1:0] x_dly_reg [TRIG_LAT];
    logic signed [COORD_WIDTH-1:0] y_dly_reg [TRIG_LAT];
    logic signed [COORD_WIDTH-1:0] z_dly_reg [TRIG_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_dly_reg[0] <= point.vec_x;
            y_dly_reg[0] <= point.vec_y;
            z_dly_reg[0] <= point.vec_z;
            for (int i = 1; i < TRIG_LAT; i++)
            begin
                x_dly_reg[i] <= x_dly_reg[i-1];
                y_dly_reg[i] <= y_dly_reg[i-1];
                z_dly_reg[i] <= z_dly_reg[i-1];
            end
        end
    end

    logic signed [TW-1:0] sr, cr, sp, cp, sy, cy;

    erv_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_roll (
        .clk(clk), .en(adv), .angle(point.roll_deg), .sin_val(sr), .cos_val(cr)
    );
    erv_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_pitch (
        .clk(clk), .en(adv), .angle(point.pitch_deg), .sin_val(sp), .cos_val(cp)
    );
    erv_trig #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_trig_yaw (
        .clk(clk), .en(adv), .angle(point.yaw_deg), .sin_val(sy), .cos_val(cy)
    );

    // operands that skip a rotation step are delayed to match it
    logic signed [COORD_WIDTH-1:0] x_s1_reg [ROT_LAT];
    logic signed [TW-1:0]          sp_s1_reg [ROT_LAT];
    logic signed [TW-1:0]          cp_s1_reg [ROT_LAT];
    logic signed [TW-1:0]          sy_s1_reg [ROT_LAT];
    logic signed [TW-1:0]          cy_s1_reg [ROT_LAT];
    logic signed [COORD_WIDTH-1:0] y1_s2_reg [ROT_LAT];
    logic signed [TW-1:0]          sy_s2_reg [ROT_LAT];
    logic signed [TW-1:0]          cy_s2_reg [ROT_LAT];
    logic signed [COORD_WIDTH-1:0] z2_s3_reg [ROT_LAT];

    logic signed [COORD_WIDTH-1:0] y1, z1, z2, x2, x3, y3;
    logic                          ovf1, ovf2, ovf3;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_s1_reg[0]  <= x_dly_reg[TRIG_LAT-1];
            sp_s1_reg[0] <= sp;
            cp_s1_reg[0] <= cp;
            sy_s1_reg[0] <= sy;
            cy_s1_reg[0] <= cy;
            y1_s2_reg[0] <= y1;
            sy_s2_reg[0] <= sy_s1_reg[ROT_LAT-1];
            cy_s2_reg[0] <= cy_s1_reg[ROT_LAT-1];
            z2_s3_reg[0] <= z2;
            for (int i = 1; i < ROT_LAT; i++)
            begin
                x_s1_reg[i]  <= x_s1_reg[i-1];
                sp_s1_reg[i] <= sp_s1_reg[i-1];
                cp_s1_reg[i] <= cp_s1_reg[i-1];
                sy_s1_reg[i] <= sy_s1_reg[i-1];
                cy_s1_reg[i] <= cy_s1_reg[i-1];
                y1_s2_reg[i] <= y1_s2_reg[i-1];
                sy_s2_reg[i] <= sy_s2_reg[i-1];
                cy_s2_reg[i] <= cy_s2_reg[i-1];
                z2_s3_reg[i] <= z2_s3_reg[i-1];
            end
        end
    end

    // about X: y1 = y*cr - z*sr, z1 = y*sr + z*cr
    erv_rot_step #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_x (
        .clk(clk), .en(adv),
        .a(y_dly_reg[TRIG_LAT-1]), .b(z_dly_reg[TRIG_LAT-1]), .c(cr), .s(sr),
        .ovf_in(1'b0), .diff_val(y1), .sum_val(z1), .ovf_out(ovf1)
    );

    // about Y: z2 = z1*cp - x*sp, x2 = z1*sp + x*cp
    erv_rot_step #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_y (
        .clk(clk), .en(adv),
        .a(z1), .b(x_s1_reg[ROT_LAT-1]), .c(cp_s1_reg[ROT_LAT-1]), .s(sp_s1_reg[ROT_LAT-1]),
        .ovf_in(ovf1), .diff_val(z2), .sum_val(x2), .ovf_out(ovf2)
    );

    // about Z: x3 = x2*cy - y1*sy, y3 = x2*sy + y1*cy
    erv_rot_step #(.COORD_WIDTH(COORD_WIDTH), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_rot_z (
        .clk(clk), .en(adv),
        .a(x2), .b(y1_s2_reg[ROT_LAT-1]), .c(cy_s2_reg[ROT_LAT-1]), .s(sy_s2_reg[ROT_LAT-1]),
        .ovf_in(ovf2), .diff_val(x3), .sum_val(y3), .ovf_out(ovf3)
    );

    assign last.x   = x3;
    assign last.y   = y3;
    assign last.z   = z2_s3_reg[ROT_LAT-1];
    assign last.ovf = ovf3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            skid_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                valid_reg <= {valid_reg[PIPE_LAT-2:0], point.valid};

            if (!out_valid_reg || result.ready)
            begin
                if (skid_full_reg)
                begin
                    out_valid_reg <= 1'b1;
                    skid_full_reg <= 1'b0;
                end
                else
                    out_valid_reg <= valid_reg[PIPE_LAT-1];
            end
            else if (adv && valid_reg[PIPE_LAT-1])
                skid_full_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
            out_reg <= skid_full_reg ? skid_reg : last;
        else if (adv)
            skid_reg <= last;
    end

    assign result.valid    = out_valid_reg;
    assign result.rot_x    = out_reg.x;
    assign result.rot_y    = out_reg.y;
    assign result.rot_z    = out_reg.z;
    assign result.overflow = out_reg.ovf;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// testbench for euler_rotate_vector3: drives random and table points and angles,
// checks every rotated point against a table value or an in-bench fixed point predictor
// depends on erv_pkg, erv_if and the rtl of the block
module tb;
    import erv_pkg::*;

    localparam int CW = 32;
    localparam int TFB = 16;
    localparam int N_RANDOM = 930;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic signed [31:0]   roll;
        logic signed [31:0]   pitch;
        logic signed [31:0]   yaw;
    } point_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic                 ovf;
    } rotated_t;

    typedef struct {
        point_t   p;
        bit       known;
        rotated_t r;
    } stim_row_t;

    logic clk;
    logic rst_n;
    erv_in_if  #(.COORD_WIDTH(CW)) point ();
    erv_out_if #(.COORD_WIDTH(CW)) result ();

    euler_rotate_vector3 #(.COORD_WIDTH(CW), .TRIG_FRAC_BITS(TFB)) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .point(point),
        .result(result)
    );

    rotated_t expected_rotations[$];
    int mismatches;
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // sine and cosine of a Q16.16 angle in degrees, TFB fraction bits
    function automatic void angle_trig(input logic signed [31:0] ang, output longint sn,
                                       output longint cs);
        longint m, q, ss, cc, s, c;
        longint unsigned r, th, x2, ts, tc;
        begin
            m = longint'(ang) % (64'sd360 * 65536);
            if (m < 0)
                m += 64'sd360 * 65536;
            q = m / (64'sd90 * 65536);
            r = longint'(m % (64'sd90 * 65536));
            th = (r * 64'd19190098069) >> 26;
            x2 = (th * th) >> 30;
            ts = th;
            tc = 64'd1 << 30;
            ss = th;
            cc = 64'sd1 << 30;
            for (int k = 1; k <= 7; k++)
            begin
                ts = ((ts * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                tc = ((tc * x2) >> 30) / longint'((2 * k - 1) * (2 * k));
                if (k % 2 == 1)
                begin
                    ss -= longint'(ts);
                    cc -= longint'(tc);
                end
                else
                begin
                    ss += longint'(ts);
                    cc += longint'(tc);
                end
            end
            s = (ss < 0) ? 0 : (ss > (64'sd1 << 30) ? (64'sd1 << 30) : ss);
            c = (cc < 0) ? 0 : (cc > (64'sd1 << 30) ? (64'sd1 << 30) : cc);
            s = (s + (64'sd1 << (29 - TFB))) >>> (30 - TFB);
            c = (c + (64'sd1 << (29 - TFB))) >>> (30 - TFB);
            case (q)
                0: begin sn = s;  cs = c;  end
                1: begin sn = c;  cs = -s; end
                2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        end
    endfunction

    // a*ta + b*tb, rounded half up, saturated to CW bits
    function automatic longint mix(longint a, longint ta, longint b, longint tb,
                                   ref bit ovf);
        logic signed [127:0] acc;
        longint maxv, minv;
        begin
            maxv = (64'sd1 <<< (CW - 1)) - 1;
            minv = -maxv - 1;
            acc = 128'(a) * 128'(ta) + 128'(b) * 128'(tb) + (128'sd1 <<< (TFB - 1));
            acc = acc >>> TFB;
            if (acc > maxv)
            begin
                ovf = 1'b1;
                return maxv;
            end
            if (acc < minv)
            begin
                ovf = 1'b1;
                return minv;
            end
            return longint'(acc);
        end
    endfunction

    function automatic rotated_t rotate_point(point_t p);
        longint sr, cr, sp, cp, sy, cy, y1, z1, x2, z2, x3, y3;
        bit ovf;
        rotated_t r;
        begin
            ovf = 1'b0;
            angle_trig(p.roll, sr, cr);
            angle_trig(p.pitch, sp, cp);
            angle_trig(p.yaw, sy, cy);
            y1 = mix(p.y, cr, p.z, -sr, ovf);
            z1 = mix(p.y, sr, p.z, cr, ovf);
            x2 = mix(p.x, cp, z1, sp, ovf);
            z2 = mix(p.x, -sp, z1, cp, ovf);
            x3 = mix(x2, cy, y1, -sy, ovf);
            y3 = mix(x2, sy, y1, cy, ovf);
            r.x = x3[CW-1:0];
            r.y = y3[CW-1:0];
            r.z = z2[CW-1:0];
            r.ovf = ovf;
            return r;
        end
    endfunction

    function automatic logic signed [31:0] random_angle();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 360) << 16;
            1: return -($urandom_range(0, 720) << 16);
            2: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
            1: return $signed($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    // valid drops only when a gap follows, so back to back requests keep it high
    task automatic send_point(input point_t p, input bit known, input rotated_t r);
        int gap;
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                point.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            point.valid <= 1'b1;
            point.vec_x <= p.x;
            point.vec_y <= p.y;
            point.vec_z <= p.z;
            point.roll_deg <= p.roll;
            point.pitch_deg <= p.pitch;
            point.yaw_deg <= p.yaw;
            expected_rotations.push_back(known ? r : rotate_point(p));
            @(posedge clk);
            while (!point.ready)
                @(posedge clk);
        end
    endtask

    // sink side: random stall per result
    initial
    begin
        int stall;
        rotated_t want;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 10);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
            while (!result.valid)
                @(posedge clk);
            if (expected_rotations.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%0d y=%0d z=%0d", result.rot_x,
                             result.rot_y, result.rot_z);
            end
            else
            begin
                want = expected_rotations.pop_front();
                if (result.rot_x !== want.x || result.rot_y !== want.y ||
                    result.rot_z !== want.z || result.overflow !== want.ovf)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %0d %0d %0d ovf %0b, got %0d %0d %0d ovf %0b",
                                 want.x, want.y, want.z, want.ovf, result.rot_x,
                                 result.rot_y, result.rot_z, result.overflow);
                end
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        point_t p;
        rotated_t none;
        int drain;
        none = '0;
        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        point.valid = 1'b0;
        point.vec_x = '0;
        point.vec_y = '0;
        point.vec_z = '0;
        point.roll_deg = '0;
        point.pitch_deg = '0;
        point.yaw_deg = '0;

        // zero angles leave the point as is; extremes of coords and angles
        rows.push_back('{'{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 0, 0, 0},
                         1, '{32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0}});
        rows.push_back('{'{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0},
                         1, '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0}});
        rows.push_back('{'{0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff},
                         1, '{0, 0, 0, 1'b0}});
        // full turns and negative angles
        rows.push_back('{'{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                           360 << 16, -(360 << 16), 720 << 16},
                         1, '{32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 1'b0}});
        // quadrant boundaries
        rows.push_back('{'{32'sh0001_0000, 0, 0, 0, 0, 90 << 16}, 0, none});
        rows.push_back('{'{32'sh0001_0000, 0, 0, 0, 0, 180 << 16}, 0, none});
        rows.push_back('{'{32'sh0001_0000, 0, 0, 0, 0, 270 << 16}, 0, none});
        rows.push_back('{'{0, 32'sh0001_0000, 0, -(90 << 16), 0, 0}, 0, none});
        rows.push_back('{'{0, 0, 32'sh0001_0000, 0, 45 << 16, 0}, 0, none});
        rows.push_back('{'{32'sh0001_0000, 0, 0, 0, 0, (90 << 16) - 1}, 0, none});
        // saturation at 45 degrees with large coordinates, then small coordinates at mixed angles
        rows.push_back('{'{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                           45 << 16, 45 << 16, 45 << 16}, 0, none});
        rows.push_back('{'{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                           -(45 << 16), 135 << 16, 225 << 16}, 0, none});
        rows.push_back('{'{32'shffff_ffff, 32'sh0000_0001, 32'shffff_ffff,
                           30 << 16, 60 << 16, 315 << 16}, 0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_point(rows[i].p, rows[i].known, rows[i].r);
        for (int n = 0; n < N_RANDOM; n++)
        begin
            p.x = random_coord();
            p.y = random_coord();
            p.z = random_coord();
            p.roll = random_angle();
            p.pitch = random_angle();
            p.yaw = random_angle();
            send_point(p, 1'b0, none);
        end
        point.valid <= 1'b0;

        while (expected_rotations.size() != 0)
            @(posedge clk);
        drain = 0;
        while (drain < 2 * (TRIG_LAT + 3 * ROT_LAT + 2))
        begin
            @(posedge clk);
            drain++;
        end
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
